FILE: design/ptf_pkg.sv
// Package for the pressure trend forecast block.
// Holds sizing constants, the forecast code type and the trend state struct.
// No dependencies.
`timescale 1ns / 1ps

package ptf_pkg;

    localparam int WINDOW_COUNT     = 9;
    localparam int SLOTS_PER_WINDOW = 6;
    localparam int PRESSURE_BITS    = 17;

    localparam int WINDOW_SPACING = 30;
    localparam int SPAN_DIVISOR   = 5;
    localparam int LIMIT_SCALE    = SLOTS_PER_WINDOW * SPAN_DIVISOR;
    localparam int READY_MINUTE   = WINDOW_SPACING + SLOTS_PER_WINDOW;
    localparam int LAST_MINUTE    = WINDOW_SPACING * (WINDOW_COUNT - 1) + SLOTS_PER_WINDOW - 1;
    // window whose old samples get reused after the wrap
    localparam int REUSE_WINDOW   = WINDOW_COUNT - 2;

    localparam int SUM_W  = $clog2(((2 ** PRESSURE_BITS) - 1) * SLOTS_PER_WINDOW + 1);
    localparam int DIFF_W = SUM_W + 1;
    localparam int CNT_W  = $clog2(LAST_MINUTE + 1);
    localparam int WIN_W  = $clog2(WINDOW_COUNT + 1);
    localparam int OFF_W  = $clog2(WINDOW_SPACING);
    localparam int STEP_W = WIN_W;
    localparam int THR_W  = 8;
    localparam int LIM_W  = THR_W + STEP_W + $clog2(LIMIT_SCALE + 1);
    localparam int CMP_W  = ((DIFF_W > LIM_W) ? DIFF_W : LIM_W) + 2;
    localparam int FC_W   = 3;

    // APB register map
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_STRONG = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_WEAK   = 1'b1;
    localparam logic [THR_W-1:0] STRONG_RESET = 8'd25;
    localparam logic [THR_W-1:0] WEAK_RESET   = 8'd5;

    typedef enum logic [FC_W-1:0] {
        FC_STABLE    = 3'd0,
        FC_SUNNY     = 3'd1,
        FC_RAINY     = 3'd2,
        FC_UNSTABLE  = 3'd3,
        FC_STORM     = 3'd4,
        FC_UNKNOWN   = 3'd5
    } fc_t;

    typedef struct packed {
        logic [DIFF_W-1:0] trend;   // two's complement
        logic [STEP_W-1:0] steps;
        logic [CNT_W-1:0]  minute;
    } trend_state_t;

endpackage

FILE: design/ptf_cfg_regs.sv
// APB register file: strong and weak change thresholds.
// Depends on ptf_pkg.
`timescale 1ns / 1ps

module ptf_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptf_pkg::ADDR_W-1:0]    paddr,
    input  logic [ptf_pkg::DATA_W-1:0]    pwdata,
    output logic [ptf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [ptf_pkg::THR_W-1:0]     strong_thr,
    output logic [ptf_pkg::THR_W-1:0]     weak_thr
);

    logic [ptf_pkg::THR_W-1:0]     strong_reg;
    logic [ptf_pkg::THR_W-1:0]     weak_reg;
    logic [ptf_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ptf_pkg::REG_IDX_W+1:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strong_reg <= ptf_pkg::STRONG_RESET;
            weak_reg   <= ptf_pkg::WEAK_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ptf_pkg::REG_STRONG: strong_reg <= pwdata[ptf_pkg::THR_W-1:0];
                ptf_pkg::REG_WEAK:   weak_reg   <= pwdata[ptf_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            ptf_pkg::REG_STRONG: prdata[ptf_pkg::THR_W-1:0] = strong_reg;
            ptf_pkg::REG_WEAK:   prdata[ptf_pkg::THR_W-1:0] = weak_reg;
            default:             prdata = '0;
        endcase
    end

    assign strong_thr = strong_reg;
    assign weak_thr   = weak_reg;

endmodule

FILE: design/ptf_trend_state.sv
// Minute counter, window slots, running window sums and trend registers.
// One sample or tick transfer is folded into the state per cycle. Depends on ptf_pkg.
`timescale 1ns / 1ps

module ptf_trend_state
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tick_fire,
    input  logic                               sample_fire,
    input  logic [ptf_pkg::PRESSURE_BITS-1:0]  sample,
    output ptf_pkg::trend_state_t              state
);

    localparam int NSLOT = ptf_pkg::SLOTS_PER_WINDOW - 1;  // slots held before the last

    logic [ptf_pkg::CNT_W-1:0]  minute_reg, minute_next, minute_adv;
    logic [ptf_pkg::WIN_W-1:0]  win_reg, win_next, win_adv;
    logic [ptf_pkg::OFF_W-1:0]  off_reg, off_next, off_adv;
    logic                       pending_reg, pending_next;
    logic [ptf_pkg::DIFF_W-1:0] trend_reg, trend_next;
    logic [ptf_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [ptf_pkg::SUM_W-1:0]  wsum_reg  [ptf_pkg::WINDOW_COUNT];
    logic [ptf_pkg::SUM_W-1:0]  wsum_wr   [ptf_pkg::WINDOW_COUNT];
    logic [ptf_pkg::SUM_W-1:0]  wsum_next [ptf_pkg::WINDOW_COUNT];

    // current window slots, and a copy of the reused window's slots
    logic [ptf_pkg::PRESSURE_BITS-1:0] cur_slot_reg [NSLOT];
    logic [ptf_pkg::PRESSURE_BITS-1:0] rsv_slot_reg [NSLOT];

    logic                      in_window;
    logic                      last_slot;
    logic                      reuse_win;
    logic                      wrap;
    logic [ptf_pkg::SUM_W-1:0] win_sum;

    // counter advance on a pending tick
    always_comb
    begin
        minute_adv = minute_reg;
        win_adv    = win_reg;
        off_adv    = off_reg;
        if (pending_reg)
        begin
            minute_adv = minute_reg + 1'b1;
            if (off_reg == ptf_pkg::OFF_W'(ptf_pkg::WINDOW_SPACING - 1))
            begin
                off_adv = '0;
                win_adv = win_reg + 1'b1;
            end
            else
            begin
                off_adv = off_reg + 1'b1;
            end
        end
    end

    assign in_window = (win_adv < ptf_pkg::WIN_W'(ptf_pkg::WINDOW_COUNT))
                     && (off_adv < ptf_pkg::OFF_W'(ptf_pkg::SLOTS_PER_WINDOW));
    assign last_slot = (off_adv == ptf_pkg::OFF_W'(ptf_pkg::SLOTS_PER_WINDOW - 1));
    assign reuse_win = (win_adv == ptf_pkg::WIN_W'(ptf_pkg::REUSE_WINDOW));
    assign wrap      = (minute_adv == ptf_pkg::CNT_W'(ptf_pkg::LAST_MINUTE));

    // window sum: held slots plus the incoming sample in the last slot
    always_comb
    begin
        win_sum = ptf_pkg::SUM_W'(sample);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (reuse_win)
                win_sum = win_sum + ptf_pkg::SUM_W'(rsv_slot_reg[i]);
            else
                win_sum = win_sum + ptf_pkg::SUM_W'(cur_slot_reg[i]);
        end
    end

    always_comb
    begin
        minute_next  = minute_reg;
        win_next     = win_reg;
        off_next     = off_reg;
        pending_next = pending_reg;
        trend_next   = trend_reg;
        steps_next   = steps_reg;
        for (int i = 0; i < ptf_pkg::WINDOW_COUNT; i++)
            wsum_wr[i] = wsum_reg[i];

        if (sample_fire && in_window && last_slot)
        begin
            for (int i = 0; i < ptf_pkg::WINDOW_COUNT; i++)
            begin
                if (win_adv == ptf_pkg::WIN_W'(i))
                    wsum_wr[i] = win_sum;
            end
        end

        for (int i = 0; i < ptf_pkg::WINDOW_COUNT; i++)
            wsum_next[i] = wsum_wr[i];

        if (tick_fire)
        begin
            pending_next = 1'b1;
        end
        else if (sample_fire)
        begin
            pending_next = 1'b0;
            minute_next  = minute_adv;
            win_next     = win_adv;
            off_next     = off_adv;
            if (in_window && last_slot)
            begin
                if (win_adv != '0)
                begin
                    trend_next = {1'b0, win_sum} - {1'b0, wsum_reg[0]};
                    steps_next = ptf_pkg::STEP_W'(win_adv);
                end
                if (wrap)
                begin
                    minute_next = minute_adv - ptf_pkg::CNT_W'(ptf_pkg::WINDOW_SPACING);
                    win_next    = win_adv - 1'b1;
                    for (int i = 0; i < ptf_pkg::WINDOW_COUNT - 1; i++)
                        wsum_next[i] = wsum_wr[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minute_reg  <= '0;
            win_reg     <= '0;
            off_reg     <= '0;
            pending_reg <= 1'b0;
            trend_reg   <= '0;
            steps_reg   <= '0;
            for (int i = 0; i < ptf_pkg::WINDOW_COUNT; i++)
                wsum_reg[i] <= '0;
        end
        else
        begin
            minute_reg  <= minute_next;
            win_reg     <= win_next;
            off_reg     <= off_next;
            pending_reg <= pending_next;
            trend_reg   <= trend_next;
            steps_reg   <= steps_next;
            for (int i = 0; i < ptf_pkg::WINDOW_COUNT; i++)
                wsum_reg[i] <= wsum_next[i];
        end
    end

    // slot storage, payload only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            if (sample_fire && in_window && off_adv == ptf_pkg::OFF_W'(i))
            begin
                cur_slot_reg[i] <= sample;
                if (reuse_win)
                    rsv_slot_reg[i] <= sample;
            end
        end
    end

    assign state.trend  = trend_reg;
    assign state.steps  = steps_reg;
    assign state.minute = minute_reg;

endmodule

FILE: design/ptf_classifier.sv
// Forecast classification and the result output register.
// Compares the trend against scaled thresholds. Depends on ptf_pkg.
`timescale 1ns / 1ps

module ptf_classifier
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    output logic                          res_take,
    input  ptf_pkg::trend_state_t         state,
    input  logic [ptf_pkg::THR_W-1:0]     strong_thr,
    input  logic [ptf_pkg::THR_W-1:0]     weak_thr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ptf_pkg::FC_W-1:0]      forecast,
    output logic [ptf_pkg::DIFF_W-1:0]    trend_difference,
    output logic [ptf_pkg::STEP_W-1:0]    trend_span,
    output logic [ptf_pkg::CNT_W-1:0]     minute_index
);

    logic                        out_valid_reg, out_valid_next;
    ptf_pkg::fc_t                fc_reg, fc_next;
    logic [ptf_pkg::DIFF_W-1:0]  diff_reg;
    logic [ptf_pkg::STEP_W-1:0]  span_reg;
    logic [ptf_pkg::CNT_W-1:0]   minute_reg;

    logic [ptf_pkg::LIM_W-1:0]   s_lim, w_lim;
    logic signed [ptf_pkg::CMP_W-1:0] d, s, w;

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        s_lim = {{(ptf_pkg::LIM_W-ptf_pkg::THR_W){1'b0}}, strong_thr}
              * {{(ptf_pkg::LIM_W-ptf_pkg::STEP_W){1'b0}}, state.steps}
              * ptf_pkg::LIM_W'(ptf_pkg::LIMIT_SCALE);
        w_lim = {{(ptf_pkg::LIM_W-ptf_pkg::THR_W){1'b0}}, weak_thr}
              * {{(ptf_pkg::LIM_W-ptf_pkg::STEP_W){1'b0}}, state.steps}
              * ptf_pkg::LIM_W'(ptf_pkg::LIMIT_SCALE);
        d = {{(ptf_pkg::CMP_W-ptf_pkg::DIFF_W){state.trend[ptf_pkg::DIFF_W-1]}}, state.trend};
        s = {{(ptf_pkg::CMP_W-ptf_pkg::LIM_W){1'b0}}, s_lim};
        w = {{(ptf_pkg::CMP_W-ptf_pkg::LIM_W){1'b0}}, w_lim};

        // priority: storm, unstable, rainy, sunny, stable; early minutes and exact edges give unknown
        if (state.minute < ptf_pkg::CNT_W'(ptf_pkg::READY_MINUTE))
            fc_next = ptf_pkg::FC_UNKNOWN;
        else if (d < -s)
            fc_next = ptf_pkg::FC_STORM;
        else if (d > s)
            fc_next = ptf_pkg::FC_UNSTABLE;
        else if (d > -s && d < -w)
            fc_next = ptf_pkg::FC_RAINY;
        else if (d > w && d < s)
            fc_next = ptf_pkg::FC_SUNNY;
        else if (d > -w && d < w)
            fc_next = ptf_pkg::FC_STABLE;
        else
            fc_next = ptf_pkg::FC_UNKNOWN;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            fc_reg     <= fc_next;
            diff_reg   <= state.trend;
            span_reg   <= state.steps;
            minute_reg <= state.minute;
        end
    end

    assign out_valid        = out_valid_reg;
    assign forecast         = fc_reg;
    assign trend_difference = diff_reg;
    assign trend_span       = span_reg;
    assign minute_index     = minute_reg;

endmodule

FILE: design/pressure_trend_forecast_top.sv
// Pressure trend forecast, top level.
// A sample's result passes the input register, the state update and the classifier
// into the output register. A tick gives no result and never waits on the output.
// Throughput: one item per cycle while the output does not stall a sample.
// Reset (rst_n, async low): counter, sums, trend and valids cleared, thresholds 25 and 5.
`timescale 1ns / 1ps

module pressure_trend_forecast_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptf_pkg::ADDR_W-1:0]          paddr,
    input  logic [ptf_pkg::DATA_W-1:0]          pwdata,
    output logic [ptf_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [ptf_pkg::PRESSURE_BITS-1:0]   pressure,
    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ptf_pkg::FC_W-1:0]            forecast,
    output logic [ptf_pkg::DIFF_W-1:0]          trend_difference,
    output logic [ptf_pkg::STEP_W-1:0]          trend_span,
    output logic [ptf_pkg::CNT_W-1:0]           minute_index
);

    // Stage A: input register. Stage B: the state registers hold the result
    // of a sample that still has to be classified. Stage C: output register.
    logic                               a_valid_reg;
    logic                               a_kind_reg;
    logic [ptf_pkg::PRESSURE_BITS-1:0]  a_pres_reg;
    logic                               a_fire;
    logic                               b_valid_reg, b_valid_next;
    logic                               b_take;

    logic [ptf_pkg::THR_W-1:0]          strong_thr;
    logic [ptf_pkg::THR_W-1:0]          weak_thr;
    ptf_pkg::trend_state_t              state;

    ptf_cfg_regs u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .strong_thr (strong_thr),
        .weak_thr   (weak_thr)
    );

    // A tick only touches the pending flag, so it can always move on.
    // A sample changes the state, so it waits until the previous result
    // has been picked up by the output stage.
    assign a_fire   = a_valid_reg && (a_kind_reg || !b_valid_reg || b_take);
    assign in_ready = !a_valid_reg || a_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_kind_reg <= kind;
            a_pres_reg <= pressure;
        end
    end

    ptf_trend_state u_state
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_fire   (a_fire && a_kind_reg),
        .sample_fire (a_fire && !a_kind_reg),
        .sample      (a_pres_reg),
        .state       (state)
    );

    always_comb
    begin
        b_valid_next = b_valid_reg && !b_take;
        if (a_fire && !a_kind_reg)
            b_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    ptf_classifier u_cls
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .res_valid        (b_valid_reg),
        .res_take         (b_take),
        .state            (state),
        .strong_thr       (strong_thr),
        .weak_thr         (weak_thr),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .forecast         (forecast),
        .trend_difference (trend_difference),
        .trend_span       (trend_span),
        .minute_index     (minute_index)
    );

    // A pending sample result is never dropped while the output stalls.
    a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_take |=> b_valid_reg)
        else $error("pending sample result lost");

    // The counter wraps at the last minute, so it is never shown past it.
    a_minute_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> minute_index <= ptf_pkg::CNT_W'(ptf_pkg::LAST_MINUTE))
        else $error("minute counter beyond last minute");

    // Early minutes always give unknown.
    a_early_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && minute_index < ptf_pkg::CNT_W'(ptf_pkg::READY_MINUTE)
        |-> forecast == ptf_pkg::FC_UNKNOWN)
        else $error("forecast given before ready minute");

    // A known forecast needs a trend over at least one window.
    a_span_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && forecast != ptf_pkg::FC_UNKNOWN |-> trend_span != '0)
        else $error("forecast without trend span");

endmodule
